// ===== rtl/core/a2b_pkg.sv =====
// a2b_pkg: shared types, constants and sine and cosine lookup tables for the binary angle core
// sine and cosine tables are built at elaboration from a fixed-point taylor series
// no dependencies
package a2b_pkg;

   localparam int ANGLE_BITS    = 9;
   localparam int CNT_BITS      = 6;
   localparam int LEVELS        = 6;
   localparam int TAB_DEPTH     = 64;
   localparam int SERIES_TERMS  = 12;
   localparam int OUT_DATA_BITS = ((ANGLE_BITS + 7) / 8) * 8;
   localparam int HALF_WORD     = 32;

   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [ANGLE_BITS-1:0] angle_type;
   typedef logic [CNT_BITS:0]     mag_type;
   typedef logic [63:0]           q64_type;
   typedef q64_type               q64_tab_type [TAB_DEPTH];
   typedef q64_type               div_tab_type [SERIES_TERMS];

   localparam q64_type   STEP_Q64      = 64'h03243F6A8885A309;
   localparam angle_type ZERO_TURN     = 9'd0;
   localparam angle_type QUARTER_TURN  = 9'd128;
   localparam angle_type HALF_TURN     = 9'd256;
   localparam angle_type THREE_QUARTER = 9'd384;
   localparam mag_type   EQUAL_MAG     = 7'd64;

   localparam div_tab_type SIN_DIV = '{
      64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };
   localparam div_tab_type COS_DIV = '{
      64'd12,  64'd30,  64'd56,  64'd90,  64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650
   };

   typedef struct packed {
      logic both_zero;
      logic swapped;
      logic ref_neg;
      logic quarter_neg;
      logic equal;
   } ctl_type;

   function automatic q64_type mul_hi(input q64_type a, input q64_type b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
   endfunction

   function automatic q64_tab_type build_sin_tab();
      q64_tab_type tab;
      q64_type     a;
      q64_type     a2;
      q64_type     term;
      q64_type     sum;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         a    = STEP_Q64 * 64'(k);
         a2   = mul_hi(a, a);
         term = a;
         sum  = a;
         for (int i = 0; i < SERIES_TERMS; i++) begin
            term = mul_hi(term, a2) / SIN_DIV[i];
            if (((i + 1) % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         tab[k] = sum;
      end
      return tab;
   endfunction

   function automatic q64_tab_type build_cos_tab();
      q64_tab_type tab;
      q64_type     a;
      q64_type     a2;
      q64_type     term;
      q64_type     sum;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         a    = STEP_Q64 * 64'(k);
         a2   = mul_hi(a, a);
         term = a2 >> 1;
         sum  = 64'd0 - term;
         for (int i = 0; i < SERIES_TERMS; i++) begin
            term = mul_hi(term, a2) / COS_DIV[i];
            if (((i + 2) % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         tab[k] = sum;
      end
      return tab;
   endfunction

   localparam q64_tab_type SIN_TAB = build_sin_tab();
   localparam q64_tab_type COS_TAB = build_cos_tab();

endpackage

// ===== rtl/core/a2b_prep.sv =====
// a2b_prep: first pipeline stage, magnitudes, octant folding and special cases
// depends on a2b_pkg
module a2b_prep #(
   parameter int COORD_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [COORD_BITS-1:0]  ref_coord,
   input  logic [COORD_BITS-1:0]  quarter_coord,
   output logic                   out_valid,
   output a2b_pkg::ctl_type       out_ctl,
   output logic [COORD_BITS-1:0]  out_n,
   output logic [COORD_BITS-1:0]  out_d
);

   logic                  valid_ff;
   a2b_pkg::ctl_type      ctl_ff;
   a2b_pkg::ctl_type      ctl_in;
   logic [COORD_BITS-1:0] n_ff;
   logic [COORD_BITS-1:0] n_in;
   logic [COORD_BITS-1:0] d_ff;
   logic [COORD_BITS-1:0] d_in;
   logic [COORD_BITS-1:0] ref_mag;
   logic [COORD_BITS-1:0] quarter_mag;

   always_comb begin
      ref_mag     = ref_coord[COORD_BITS-1] ? (~ref_coord + 1'b1) : ref_coord;
      quarter_mag = quarter_coord[COORD_BITS-1] ? (~quarter_coord + 1'b1) : quarter_coord;
      ctl_in.ref_neg     = ref_coord[COORD_BITS-1];
      ctl_in.quarter_neg = quarter_coord[COORD_BITS-1];
      ctl_in.both_zero   = (ref_coord == '0) && (quarter_coord == '0);
      ctl_in.swapped     = ref_mag < quarter_mag;
      ctl_in.equal       = ref_mag == quarter_mag;
      n_in = ctl_in.swapped ? ref_mag : quarter_mag;
      d_in = ctl_in.swapped ? quarter_mag : ref_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= ctl_in;
         n_ff   <= n_in;
         d_ff   <= d_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_n     = n_ff;
   assign out_d     = d_ff;

endmodule

// ===== rtl/core/a2b_level.sv =====
// a2b_level: one bit of the arctangent binary search over three register stages
// compares n*cos(k) against d*sin(k) exactly; depends on a2b_pkg
module a2b_level #(
   parameter int COORD_BITS = 16,
   parameter int LEVEL      = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  a2b_pkg::ctl_type       in_ctl,
   input  logic [COORD_BITS-1:0]  in_n,
   input  logic [COORD_BITS-1:0]  in_d,
   input  a2b_pkg::cnt_type       in_cnt,
   output logic                   out_valid,
   output a2b_pkg::ctl_type       out_ctl,
   output logic [COORD_BITS-1:0]  out_n,
   output logic [COORD_BITS-1:0]  out_d,
   output a2b_pkg::cnt_type       out_cnt
);

   localparam int HW     = a2b_pkg::HALF_WORD;
   localparam int PART_W = COORD_BITS + HW;
   localparam int PROD_W = COORD_BITS + 2 * HW;

   a2b_pkg::cnt_type      cand;
   a2b_pkg::q64_type      cos_k;
   a2b_pkg::q64_type      sin_k;

   // stage a: table lookup and partial products
   logic                  valid_a_ff;
   a2b_pkg::ctl_type      ctl_a_ff;
   logic [COORD_BITS-1:0] n_a_ff;
   logic [COORD_BITS-1:0] d_a_ff;
   a2b_pkg::cnt_type      cnt_a_ff;
   a2b_pkg::cnt_type      cand_a_ff;
   logic [PART_W-1:0]     nch_a_ff;
   logic [PART_W-1:0]     ncl_a_ff;
   logic [PART_W-1:0]     dsh_a_ff;
   logic [PART_W-1:0]     dsl_a_ff;

   // stage b: full products
   logic                  valid_b_ff;
   a2b_pkg::ctl_type      ctl_b_ff;
   logic [COORD_BITS-1:0] n_b_ff;
   logic [COORD_BITS-1:0] d_b_ff;
   a2b_pkg::cnt_type      cnt_b_ff;
   a2b_pkg::cnt_type      cand_b_ff;
   logic [PROD_W-1:0]     lhs_b_ff;
   logic [PROD_W-1:0]     lhs_b_in;
   logic [PROD_W-1:0]     rhs_b_ff;
   logic [PROD_W-1:0]     rhs_b_in;

   // stage c: decision
   logic                  valid_c_ff;
   a2b_pkg::ctl_type      ctl_c_ff;
   logic [COORD_BITS-1:0] n_c_ff;
   logic [COORD_BITS-1:0] d_c_ff;
   a2b_pkg::cnt_type      cnt_c_ff;
   a2b_pkg::cnt_type      cnt_c_in;

   always_comb begin
      cand  = in_cnt | a2b_pkg::cnt_type'(1 << LEVEL);
      cos_k = a2b_pkg::COS_TAB[cand];
      sin_k = a2b_pkg::SIN_TAB[cand];
   end

   always_comb begin
      lhs_b_in = {nch_a_ff, {HW{1'b0}}} + {{HW{1'b0}}, ncl_a_ff};
      rhs_b_in = {dsh_a_ff, {HW{1'b0}}} + {{HW{1'b0}}, dsl_a_ff};
      cnt_c_in = (lhs_b_ff >= rhs_b_ff) ? cand_b_ff : cnt_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_a_ff  <= in_ctl;
         n_a_ff    <= in_n;
         d_a_ff    <= in_d;
         cnt_a_ff  <= in_cnt;
         cand_a_ff <= cand;
         nch_a_ff  <= {{HW{1'b0}}, in_n} * {{COORD_BITS{1'b0}}, cos_k[2*HW-1:HW]};
         ncl_a_ff  <= {{HW{1'b0}}, in_n} * {{COORD_BITS{1'b0}}, cos_k[HW-1:0]};
         dsh_a_ff  <= {{HW{1'b0}}, in_d} * {{COORD_BITS{1'b0}}, sin_k[2*HW-1:HW]};
         dsl_a_ff  <= {{HW{1'b0}}, in_d} * {{COORD_BITS{1'b0}}, sin_k[HW-1:0]};

         ctl_b_ff  <= ctl_a_ff;
         n_b_ff    <= n_a_ff;
         d_b_ff    <= d_a_ff;
         cnt_b_ff  <= cnt_a_ff;
         cand_b_ff <= cand_a_ff;
         lhs_b_ff  <= lhs_b_in;
         rhs_b_ff  <= rhs_b_in;

         ctl_c_ff  <= ctl_b_ff;
         n_c_ff    <= n_b_ff;
         d_c_ff    <= d_b_ff;
         cnt_c_ff  <= cnt_c_in;
      end
   end

   assign out_valid = valid_c_ff;
   assign out_ctl   = ctl_c_ff;
   assign out_n     = n_c_ff;
   assign out_d     = d_c_ff;
   assign out_cnt   = cnt_c_ff;

endmodule

// ===== rtl/core/a2b_post.sv =====
// a2b_post: octant unfolding and the response output register
// depends on a2b_pkg
module a2b_post (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  a2b_pkg::ctl_type                   in_ctl,
   input  a2b_pkg::cnt_type                   in_cnt,
   output logic                               rsp_tvalid,
   output logic [a2b_pkg::OUT_DATA_BITS-1:0]  rsp_tdata,
   output logic [0:0]                         rsp_tuser
);

   localparam int PAD_BITS = a2b_pkg::OUT_DATA_BITS - a2b_pkg::ANGLE_BITS;

   logic                rsp_tvalid_ff;
   a2b_pkg::angle_type  angle_ff;
   a2b_pkg::angle_type  angle_in;
   logic                zero_ff;
   a2b_pkg::mag_type    mag;
   a2b_pkg::angle_type  base;
   a2b_pkg::angle_type  sbase;

   always_comb begin
      mag   = in_ctl.equal ? a2b_pkg::EQUAL_MAG : {1'b0, in_cnt};
      base  = {{(a2b_pkg::ANGLE_BITS - a2b_pkg::CNT_BITS - 1){1'b0}}, mag};
      sbase = (in_ctl.ref_neg ^ in_ctl.quarter_neg) ? (a2b_pkg::ZERO_TURN - base) : base;
      if (in_ctl.both_zero) begin
         angle_in = a2b_pkg::ZERO_TURN;
      end else if (!in_ctl.swapped) begin
         angle_in = sbase + (in_ctl.ref_neg ? a2b_pkg::HALF_TURN : a2b_pkg::ZERO_TURN);
      end else begin
         angle_in = (in_ctl.quarter_neg ? a2b_pkg::THREE_QUARTER : a2b_pkg::QUARTER_TURN)
                    - sbase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
         zero_ff  <= in_ctl.both_zero;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, angle_ff};
   assign rsp_tuser  = zero_ff;

endmodule

// ===== rtl/core/atan2_to_binary_angle_512_core.sv =====
// atan2_to_binary_angle_512_core: top level of the coordinate-to-binary-angle pipeline
// instantiates a2b_prep, a2b_level and a2b_post; depends on a2b_pkg
//
// usage:
//   request channel (req_*): one coordinate pair per request, taken when
//   req_tvalid and req_tready are both high at a rising clock edge.
//   response channel (rsp_*): one response per request, in request order,
//   angle in 512ths of a turn counted from the +ref axis, tuser set when
//   both coordinates are zero (angle then 0).
//   depth: 20 register stages (one folding stage, six search levels of
//   three stages each, one output register).
//   throughput: one request per cycle while the output is not stalled, every
//   stage registered; the six-level binary search, each level one exact
//   n*cos against d*sin compare split over three stages, sets the depth.
//   stall: while a response waits with rsp_tready low the whole pipeline
//   holds and req_tready is low; nothing is dropped or repeated.
//   reset: synchronous, active high; clears every valid bit, the pipeline
//   comes out empty and ready.
module atan2_to_binary_angle_512_core #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // ref_coord, quarter_coord, zero pad
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // angle, zero pad
   output logic [a2b_pkg::OUT_DATA_BITS-1:0]  rsp_tdata,
   // both_zero
   output logic [0:0]                         rsp_tuser
);

   localparam int LEVELS = a2b_pkg::LEVELS;

   logic                  en;
   logic                  valid_c [LEVELS+1];
   a2b_pkg::ctl_type      ctl_c   [LEVELS+1];
   logic [COORD_BITS-1:0] n_c     [LEVELS+1];
   logic [COORD_BITS-1:0] d_c     [LEVELS+1];
   a2b_pkg::cnt_type      cnt_c   [LEVELS+1];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign cnt_c[0]   = '0;

   a2b_prep #(
      .COORD_BITS(COORD_BITS)
   ) u_prep (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_tvalid),
      .ref_coord     (req_tdata[COORD_BITS-1:0]),
      .quarter_coord (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .out_valid     (valid_c[0]),
      .out_ctl       (ctl_c[0]),
      .out_n         (n_c[0]),
      .out_d         (d_c[0])
   );

   for (genvar g = 0; g < LEVELS; g++) begin : g_level
      a2b_level #(
         .COORD_BITS(COORD_BITS),
         .LEVEL     (LEVELS - 1 - g)
      ) u_level (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_c[g]),
         .in_ctl    (ctl_c[g]),
         .in_n      (n_c[g]),
         .in_d      (d_c[g]),
         .in_cnt    (cnt_c[g]),
         .out_valid (valid_c[g+1]),
         .out_ctl   (ctl_c[g+1]),
         .out_n     (n_c[g+1]),
         .out_d     (d_c[g+1]),
         .out_cnt   (cnt_c[g+1])
      );
   end

   a2b_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (valid_c[LEVELS]),
      .in_ctl     (ctl_c[LEVELS]),
      .in_cnt     (cnt_c[LEVELS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/a2b_checker.sv =====
// a2b_checker: port-level assertions for the binary angle core
// bound to atan2_to_binary_angle_512_core; depends on a2b_pkg
module a2b_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [a2b_pkg::OUT_DATA_BITS-1:0]  rsp_tdata,
   input logic [0:0]                         rsp_tuser
);

   localparam int ANGLE_BITS = a2b_pkg::ANGLE_BITS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[ANGLE_BITS-1:0] == a2b_pkg::ZERO_TURN)
      else $error("both-zero response with nonzero angle");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_no_response_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_tvalid |=> !rsp_tvalid)
      else $error("response appeared without a request");

endmodule

bind atan2_to_binary_angle_512_core a2b_checker u_a2b_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
